[hw/rtl/cef_pkg.sv]
// package for the coalescing event fifo
// types, codes, sizes and pointer helpers; depends on nothing
`default_nettype none

package cef_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REC_W = 48;
  localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(QUEUE_DEPTH);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PURGE = 2'd2;

  localparam logic [2:0] STS_APPENDED  = 3'd0;
  localparam logic [2:0] STS_COALESCED = 3'd1;
  localparam logic [2:0] STS_REJECTED  = 3'd2;
  localparam logic [2:0] STS_POPPED    = 3'd3;
  localparam logic [2:0] STS_POP_EMPTY = 3'd4;
  localparam logic [2:0] STS_PURGED    = 3'd5;

  localparam logic CFG_STATE_CODE    = 1'b0;
  localparam logic CFG_PROGRESS_CODE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_PURGE_RD,
    ST_PURGE_WR,
    ST_HEAD_RD,
    ST_HEAD_WAIT
  } state_t;

  // circular pointer add, both operands below the depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cef_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/coalescing_event_fifo.sv]
// Ordered event queue with tail coalescing and purge by handle.
// Input items arrive on s_tvalid/s_tready: s_tuser carries the command
// (push, pop, purge), s_tdata the event record. Each input item yields
// exactly one result item on m_tvalid/m_tready: m_tuser carries the status,
// m_tdata the removed count, empty flag, occupancy and the head record.
// Configuration writes (coalescing state and progress codes) use
// cfg_valid/cfg_ready and are always taken.
// Records live in a ram circular buffer with one read and one write port,
// walked by a small sequencer. A push passes the exec, push, head-read and
// head-wait states, a pop or an unused command the same without push; a
// purge adds a read and a write state per record, since every record is
// read and possibly rewritten through the single read port. s_tready is
// high only while the sequencer is idle; one item is worked at a time.
// The result sits in an output register: a stalled receiver holds it there
// while the next item is accepted and worked, and the sequencer waits only
// when that next result is ready and the register is still full.
// Reset empties the queue and clears both codes to zero; no clearing pass,
// the ram content is never looked at beyond the occupancy.
`default_nettype none

module coalescing_event_fifo
  import cef_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // handle[15:0], state_code[23:16], progress_code[39:24], media_index[47:40]
  input  wire logic [47:0] s_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // removed_count[4:0], queue_empty[5], occupancy[10:6], head_handle[26:11],
  // head_state_code[34:27], head_progress_code[50:35], head_media_index[58:51]
  output logic      [63:0] m_tdata,
  // status[2:0]
  output logic      [2:0]  m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  state_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] wcnt, wcnt_next;
  logic [CNT_W-1:0] rm, rm_next;
  logic [2:0]       status, status_next;
  logic [1:0]       cmd;
  logic [REC_W-1:0] rec;
  logic [7:0]       coal_state;
  logic [15:0]      coal_progress;

  logic             out_valid;
  logic [2:0]       out_status;
  logic [4:0]       out_removed;
  logic             out_empty;
  logic [4:0]       out_occ;
  logic [REC_W-1:0] out_head;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REC_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [REC_W-1:0] rd_data;

  logic             accept;
  logic             out_free;
  logic             coal_hit;
  logic             full;
  logic             last_entry;
  logic             purge_match;
  logic [CNT_W-1:0] tail_off;

  assign accept      = s_tvalid && s_tready;
  assign out_free    = !out_valid || m_tready;
  assign tail_off    = count - CNT_W'(1);
  assign full        = (count == CNT_W'(QUEUE_DEPTH));
  assign coal_hit    = (rec[23:16] == coal_state) && (rec[39:24] == coal_progress) &&
                       (count != '0) && (rd_data == rec);
  assign last_entry  = (idx + CNT_W'(1)) == count;
  assign purge_match = (rd_data[15:0] == rec[15:0]);

  cef_ram #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd == CMD_PUSH) begin
          state_next = ST_PUSH;
        end else if (cmd == CMD_PURGE && count != '0) begin
          state_next = ST_PURGE_RD;
        end else begin
          state_next = ST_HEAD_RD;
        end
      end
      ST_PUSH:     state_next = ST_HEAD_RD;
      ST_PURGE_RD: state_next = ST_PURGE_WR;
      ST_PURGE_WR: state_next = last_entry ? ST_HEAD_RD : ST_PURGE_RD;
      ST_HEAD_RD:  state_next = ST_HEAD_WAIT;
      ST_HEAD_WAIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_en       = 1'b0;
    wr_addr     = wrap_add(head, count[IDX_W-1:0]);
    wr_data     = rec;
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    wcnt_next   = wcnt;
    rm_next     = rm;
    status_next = status;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EXEC: begin
        idx_next  = '0;
        wcnt_next = '0;
        rm_next   = '0;
        case (cmd)
          CMD_PUSH: begin
            rd_en   = 1'b1;
            rd_addr = wrap_add(head, tail_off[IDX_W-1:0]);
          end
          CMD_POP: begin
            if (count == '0) begin
              status_next = STS_POP_EMPTY;
            end else begin
              head_next   = wrap_add(head, IDX_W'(1));
              count_next  = count - CNT_W'(1);
              status_next = STS_POPPED;
            end
          end
          CMD_PURGE: status_next = STS_PURGED;
          default:   status_next = STS_REJECTED;
        endcase
      end
      ST_PUSH: begin
        if (coal_hit) begin
          status_next = STS_COALESCED;
        end else if (full) begin
          status_next = STS_REJECTED;
        end else begin
          wr_en       = 1'b1;
          count_next  = count + CNT_W'(1);
          status_next = STS_APPENDED;
        end
      end
      ST_PURGE_RD: begin
        rd_en   = 1'b1;
        rd_addr = wrap_add(head, idx[IDX_W-1:0]);
      end
      ST_PURGE_WR: begin
        wr_addr  = wrap_add(head, wcnt[IDX_W-1:0]);
        wr_data  = rd_data;
        idx_next = idx + CNT_W'(1);
        if (purge_match) begin
          rm_next = rm + CNT_W'(1);
        end else begin
          wr_en     = 1'b1;
          wcnt_next = wcnt + CNT_W'(1);
        end
        if (last_entry) begin
          count_next = purge_match ? wcnt : wcnt + CNT_W'(1);
        end
      end
      ST_HEAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      ST_HEAD_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
      coal_state    <= '0;
      coal_progress <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (state == ST_HEAD_WAIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATE_CODE:    coal_state    <= cfg_data[7:0];
          CFG_PROGRESS_CODE: coal_progress <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    wcnt   <= wcnt_next;
    rm     <= rm_next;
    status <= status_next;
    if (accept) begin
      cmd <= s_tuser;
      rec <= s_tdata;
    end
    if (state == ST_HEAD_WAIT && out_free) begin
      out_status  <= status;
      out_removed <= 5'(rm);
      out_empty   <= (count == '0);
      out_occ     <= 5'(count);
      out_head    <= (count == '0) ? '0 : rd_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tuser   = out_status;
  assign m_tdata   = {5'b0, out_head, out_occ, out_empty, out_removed};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && !coal_hit && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && cmd == CMD_POP && count != '0) |=>
      count == $past(count) - CNT_W'(1))
    else $error("pop did not shrink the queue");

  a_purge_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PURGE_WR) |-> (wcnt <= idx && idx < count))
    else $error("purge write pointer passed read pointer");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for the coalescing event fifo
// streams commands through the stream ports and checks every result item
// against a queue-based prediction; depends on cef_pkg and the rtl top
`default_nettype none

module tb
  import cef_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int CALM_FROM = 6000;
  localparam int CALM_TO = 9000;
  localparam int HOLD_AFTER = 600;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [7:0] media;
    logic [15:0]       progress;
    logic [7:0]        state;
    logic [15:0]       handle;
  } event_rec_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] removed;
    logic       empty;
    logic [4:0] occupancy;
    event_rec_t head;
  } head_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    event_rec_t rec;
  } fifo_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fifo_item_t   pending_items[$];
  head_result_t expected_results[$];
  event_rec_t   held_records[$];
  logic [7:0]   model_state_code = '0;
  logic [15:0]  model_progress_code = '0;

  int cycle_count = 0;
  int fail_count = 0;
  int rx_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  coalescing_event_fifo DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("coalescing_event_fifo regression: fail");
      $finish;
    end
  end

  function automatic bit idle_now();
    bit roll;
    roll = ($urandom_range(99) < 24);
    return roll && (cycle_count < CALM_FROM || cycle_count >= CALM_TO);
  endfunction

  function automatic head_result_t apply_fifo_command(logic [1:0] cmd, event_rec_t rec);
    head_result_t res;
    event_rec_t survivors[$];
    res = '0;
    case (cmd)
      CMD_PUSH: begin
        if (rec.state == model_state_code && rec.progress == model_progress_code &&
            held_records.size() > 0 && held_records[$] == rec) begin
          res.status = STS_COALESCED;
        end else if (held_records.size() >= QUEUE_DEPTH) begin
          res.status = STS_REJECTED;
        end else begin
          held_records.push_back(rec);
          res.status = STS_APPENDED;
        end
      end
      CMD_POP: begin
        if (held_records.size() == 0) begin
          res.status = STS_POP_EMPTY;
        end else begin
          void'(held_records.pop_front());
          res.status = STS_POPPED;
        end
      end
      CMD_PURGE: begin
        foreach (held_records[i]) begin
          if (held_records[i].handle == rec.handle) begin
            res.removed = res.removed + 5'd1;
          end else begin
            survivors.push_back(held_records[i]);
          end
        end
        held_records = survivors;
        res.status = STS_PURGED;
      end
      default: begin
        res.status = STS_REJECTED;
      end
    endcase
    res.occupancy = 5'(held_records.size());
    res.empty = (held_records.size() == 0);
    if (held_records.size() > 0) begin
      res.head = held_records[0];
    end
    return res;
  endfunction

  // driver: valid is held until the item is taken
  always @(posedge clk) begin
    fifo_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_items.size() > 0 && !idle_now()) begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.cmd;
        s_tdata <= nxt.rec;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver with random idling and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_count++;
      if (!hold_done && rx_count >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_now();
      end
    end
  end

  // monitor: predicts on accepted input items, checks result items
  always @(posedge clk) begin
    head_result_t want;
    event_rec_t   got_head;
    logic         bad;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STATE_CODE) begin
          model_state_code = cfg_data[7:0];
        end else begin
          model_progress_code = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_fifo_command(s_tuser, event_rec_t'(s_tdata)));
      end
      if (m_tvalid && m_tready) begin
        got_head = event_rec_t'(m_tdata[58:11]);
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result item: sts=%0d data=%h", m_tuser, m_tdata);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          bad = (m_tuser != want.status) || (m_tdata[4:0] != want.removed) ||
                (m_tdata[5] != want.empty) || (m_tdata[10:6] != want.occupancy) ||
                (got_head.handle != want.head.handle) ||
                (got_head.state != want.head.state) ||
                (got_head.progress != want.head.progress) ||
                (got_head.media != want.head.media);
          if (bad) begin
            if (fail_count < 10) begin
              $display("mismatch: exp sts=%0d rm=%0d emp=%0d occ=%0d head=%h/%h/%h/%h",
                       want.status, want.removed, want.empty, want.occupancy,
                       want.head.handle, want.head.state, want.head.progress,
                       want.head.media);
              $display("          got sts=%0d rm=%0d emp=%0d occ=%0d head=%h/%h/%h/%h",
                       m_tuser, m_tdata[4:0], m_tdata[5], m_tdata[10:6],
                       got_head.handle, got_head.state, got_head.progress,
                       got_head.media);
            end
            fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_codes(logic [7:0] sc, logic [15:0] pc);
    write_reg(CFG_STATE_CODE, {8'h00, sc});
    write_reg(CFG_PROGRESS_CODE, pc);
    @(negedge clk);
  endtask

  task automatic add_item(logic [1:0] cmd, logic [15:0] h, logic [7:0] s,
                          logic [15:0] p, logic [7:0] m);
    fifo_item_t it;
    it.cmd = cmd;
    it.rec.handle = h;
    it.rec.state = s;
    it.rec.progress = p;
    it.rec.media = m;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  function automatic event_rec_t random_record(logic [7:0] sc, logic [15:0] pc);
    event_rec_t r;
    r.handle = ($urandom_range(1) == 0) ? 16'($urandom_range(5)) : 16'($urandom);
    r.state = ($urandom_range(1) == 0) ? sc : 8'($urandom);
    r.progress = ($urandom_range(1) == 0) ? pc : 16'($urandom);
    r.media = 8'($urandom);
    return r;
  endfunction

  task automatic add_random_items(int count, logic [7:0] sc, logic [15:0] pc);
    fifo_item_t it;
    event_rec_t last;
    int push_pct;
    int roll;
    last = random_record(sc, pc);
    push_pct = 60;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) push_pct = $urandom_range(25, 80);
      it.rec = random_record(sc, pc);
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        it.cmd = CMD_PUSH;
        if ($urandom_range(99) < 35) begin
          it.rec = last;
          it.rec.state = sc;
          it.rec.progress = pc;
        end
        last = it.rec;
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) it.cmd = CMD_POP;
        else if (roll < 94) it.cmd = CMD_PURGE;
        else it.cmd = CMD_UNUSED;
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    logic [7:0]  sc;
    logic [15:0] pc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sc = 8'h5A;
    pc = 16'h1234;
    set_codes(sc, pc);
    add_item(CMD_POP, 16'h0000, 8'h00, 16'h0000, 8'h00);
    add_item(CMD_PURGE, 16'h0000, 8'h00, 16'h0000, 8'h00);
    add_item(CMD_PUSH, 16'h0000, sc, pc, 8'h80);
    add_item(CMD_PUSH, 16'h0000, sc, pc, 8'h80);
    add_item(CMD_PUSH, 16'hFFFF, 8'hFF, 16'hFFFF, 8'h7F);
    add_item(CMD_PUSH, 16'h0000, sc, pc, 8'h80);
    add_item(CMD_PUSH, 16'h0000, sc, pc, 8'h80);
    add_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    for (int k = 1; k < 13; k++) begin
      add_item(CMD_PUSH, 16'(k), 8'(k), 16'h1000 + 16'(k), 8'(k));
    end
    // last record that fits carries the coalescing codes
    add_item(CMD_PUSH, 16'd13, sc, pc, 8'h0D);
    add_item(CMD_PUSH, 16'hBEEF, 8'h01, 16'h0002, 8'h03);
    add_item(CMD_PUSH, 16'd13, sc, pc, 8'h0D);
    add_item(CMD_PURGE, 16'h0000, 8'hFF, 16'hFFFF, 8'hFF);
    add_item(CMD_POP, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    add_item(CMD_POP, 16'h0000, 8'h00, 16'h0000, 8'h00);
    add_item(CMD_PURGE, 16'd5, 8'h00, 16'h0000, 8'h00);
    wait_drained();

    set_codes(8'h00, 16'h0000);
    add_random_items(460, 8'h00, 16'h0000);
    wait_drained();

    set_codes(8'hFF, 16'hFFFF);
    add_random_items(460, 8'hFF, 16'hFFFF);
    wait_drained();

    for (int ph = 0; ph < 2; ph++) begin
      sc = 8'($urandom);
      pc = 16'($urandom);
      set_codes(sc, pc);
      add_random_items(460, sc, pc);
      wait_drained();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("coalescing_event_fifo regression: pass");
    end else begin
      $display("coalescing_event_fifo regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
